@@ hw/rtl/oes_pkg.sv @@
`timescale 1ns / 1ps

package oes_pkg;

   localparam int MAX_POINTS_DEF = 128;

   // transaction field widths
   localparam int POS_W    = 20;
   localparam int PERIOD_W = 16;
   localparam int CFG_W    = 16;
   localparam int NUM_W    = 8;
   localparam int CNT_W    = 7;

   // internal widths
   localparam int VEL_W    = 32;
   localparam int ALPHA_W  = 17;
   localparam int CUTOFF_W = 24;

   // serial arithmetic units
   localparam int MUL_A_W  = 40;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = 64;
   localparam int DIV_N_W  = 64;
   localparam int DIV_D_W  = 44;
   localparam int SQRT_I_W = 64;
   localparam int SQRT_O_W = 32;

   // round(2*pi*2^16)
   localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = 24'hFF_FFFF;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CUTOFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_D_CUTOFF   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 2'd3;

   localparam logic [CFG_W-1:0] MIN_CUTOFF_RST = 16'd256;
   localparam logic [CFG_W-1:0] SPEED_GAIN_RST = 16'd0;
   localparam logic [CFG_W-1:0] D_CUTOFF_RST   = 16'd256;
   localparam logic [NUM_W-1:0] NUM_POINTS_RST = 8'd68;

endpackage

@@ hw/rtl/oes_ram.sv @@
`timescale 1ns / 1ps

module oes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/oes_mul.sv @@
`timescale 1ns / 1ps

// Shift-add multiplier, one bit of b per cycle.
module oes_mul #(
   parameter int A_W = oes_pkg::MUL_A_W,
   parameter int B_W = oes_pkg::MUL_B_W,
   parameter int P_W = oes_pkg::PROD_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [P_W-1:0] prod
);

   localparam int C_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic           busy_ff, done_ff;
   logic [C_W-1:0] cnt_ff;
   logic [P_W-1:0] acc_ff, a_sh_ff;
   logic [B_W-1:0] b_sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == C_W'(B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= P_W'(a);
         b_sh_ff <= b;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_ff <= acc_ff + a_sh_ff;
         end
         a_sh_ff <= {a_sh_ff[P_W-2:0], 1'b0};
         b_sh_ff <= {1'b0, b_sh_ff[B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ hw/rtl/oes_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module oes_div #(
   parameter int N_W = oes_pkg::DIV_N_W,
   parameter int D_W = oes_pkg::DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int C_W = $clog2(N_W);

   logic           busy_ff, done_ff;
   logic [C_W-1:0] cnt_ff;
   logic [D_W-1:0] rem_ff, dvs_ff;
   logic [N_W-1:0] quo_ff;
   logic [D_W:0]   shifted, diff;
   logic           ge;

   assign shifted = {rem_ff, quo_ff[N_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == C_W'(N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
         quo_ff <= {quo_ff[N_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/oes_sqrt.sv @@
`timescale 1ns / 1ps

// Integer square root, one root bit (two radicand bits) per cycle.
module oes_sqrt #(
   parameter int O_W = oes_pkg::SQRT_O_W,
   localparam int I_W = 2 * O_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [I_W-1:0] radicand,
   output logic           done,
   output logic [O_W-1:0] root
);

   localparam int C_W = (O_W > 1) ? $clog2(O_W) : 1;

   logic           busy_ff, done_ff;
   logic [C_W-1:0] cnt_ff;
   logic [I_W-1:0] v_sh_ff;
   logic [O_W+1:0] rem_ff;
   logic [O_W-1:0] root_ff;
   logic [O_W+3:0] shifted, trial, diff;
   logic           ge;

   assign shifted = {rem_ff, v_sh_ff[I_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign ge      = shifted >= trial;
   assign diff    = shifted - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == C_W'(O_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_sh_ff <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_sh_ff <= {v_sh_ff[I_W-3:0], 2'b00};
         rem_ff  <= ge ? diff[O_W+1:0] : shifted[O_W+1:0];
         root_ff <= {root_ff[O_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/one_euro_point_smoother.sv @@
`timescale 1ns / 1ps
// Each frame after the first runs 11 passes of the bit-serial multiplier, 4 of the restoring
// divider and 1 of the square root unit; points of the first frame skip them.
// One point in flight: a new request is accepted only after the last response is loaded.
// Reset (synchronous, active high) restores register defaults, clears the point counter,
// marks the next frame as first and empties the response register; point stores keep data.
module one_euro_point_smoother #(
   parameter int MAX_POINTS = oes_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [oes_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [oes_pkg::POS_W-1:0]    req_pos_y,
   input  logic [oes_pkg::PERIOD_W-1:0]        req_period,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [oes_pkg::POS_W-1:0]    rsp_filt_x,
   output logic signed [oes_pkg::POS_W-1:0]    rsp_filt_y,
   output logic [oes_pkg::CNT_W-1:0]           rsp_point_number,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [oes_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [oes_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LIMIT  = (MAX_POINTS < 128) ? MAX_POINTS : 128;
   localparam int POS_W  = oes_pkg::POS_W;
   localparam int VEL_W  = oes_pkg::VEL_W;
   localparam int PER_W  = oes_pkg::PERIOD_W;
   localparam int A_W    = oes_pkg::MUL_A_W;
   localparam int B_W    = oes_pkg::MUL_B_W;
   localparam int P_W    = oes_pkg::PROD_W;
   localparam int N_W    = oes_pkg::DIV_N_W;
   localparam int D_W    = oes_pkg::DIV_D_W;
   localparam int ALP_W  = oes_pkg::ALPHA_W;
   localparam int CUT_W  = oes_pkg::CUTOFF_W;
   localparam int SQ_W   = oes_pkg::SQRT_O_W;
   localparam int CNT_W  = oes_pkg::CNT_W;
   localparam int NUM_W  = oes_pkg::NUM_W;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_LOAD    = 5'd1;
   localparam logic [4:0] S_AD_MUL1 = 5'd2;
   localparam logic [4:0] S_AD_MUL2 = 5'd3;
   localparam logic [4:0] S_AD_DIV  = 5'd4;
   localparam logic [4:0] S_VX_DIV  = 5'd5;
   localparam logic [4:0] S_VX_MIX  = 5'd6;
   localparam logic [4:0] S_VY_DIV  = 5'd7;
   localparam logic [4:0] S_VY_MIX  = 5'd8;
   localparam logic [4:0] S_SQ_X    = 5'd9;
   localparam logic [4:0] S_SQ_Y    = 5'd10;
   localparam logic [4:0] S_SQRT    = 5'd11;
   localparam logic [4:0] S_GAIN    = 5'd12;
   localparam logic [4:0] S_AP_MUL1 = 5'd13;
   localparam logic [4:0] S_AP_MUL2 = 5'd14;
   localparam logic [4:0] S_AP_DIV  = 5'd15;
   localparam logic [4:0] S_PX_MIX  = 5'd16;
   localparam logic [4:0] S_PY_MIX  = 5'd17;
   localparam logic [4:0] S_DONE    = 5'd18;

   // control
   logic [4:0]       state_ff, state_in;
   logic             op_started_ff;
   logic [CNT_W-1:0] counter_ff;
   logic             first_frame_ff;
   logic             rsp_valid_ff;

   // configuration
   logic [oes_pkg::CFG_W-1:0] min_cutoff_ff, speed_gain_ff, d_cutoff_ff;
   logic [NUM_W-1:0]          num_points_ff;

   // payload
   logic signed [POS_W-1:0] cur_x_ff, cur_y_ff, pos_x_ff, pos_y_ff;
   logic [PER_W-1:0]        period_ff;
   logic [A_W-1:0]          p_ff;
   logic [D_W-1:0]          r24_ff;
   logic [ALP_W-1:0]        alpha_ff;
   logic [VEL_W-1:0]        v_ff, vel_x_ff, vel_y_ff;
   logic [P_W-1:0]          sq_ff;
   logic [SQ_W-1:0]         speed_ff;
   logic [CUT_W-1:0]        cutoff_ff;
   logic [POS_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic [CNT_W-1:0]        rsp_num_ff;
   logic                    rsp_end_ff;

   // point stores
   logic [IDX_W-1:0]         idx;
   logic [2*POS_W-1:0]       pos_rd;
   logic [2*VEL_W-1:0]       vel_rd;
   logic [POS_W-1:0]         lp_x, lp_y;
   logic [VEL_W-1:0]         lv_x, lv_y;

   // arithmetic units
   logic             mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
   logic             mul_op, div_op, sqrt_op, op_done;
   logic [A_W-1:0]   mul_a;
   logic [B_W-1:0]   mul_b;
   logic [P_W-1:0]   mul_prod;
   logic [N_W-1:0]   div_n, div_quo;
   logic [D_W-1:0]   div_d, den;
   logic [SQ_W-1:0]  sqrt_root;

   // datapath helpers
   logic             accept, out_load, last_point;
   logic [NUM_W-1:0] n_eff;
   logic [POS_W:0]   dpos_x, dpos_y, ddiff, dmag;
   logic             dneg;
   logic [VEL_W-1:0] raw_vel;
   logic [32:0]      mix_prev, mix_cur;
   logic [33:0]      mix_diff, mix_mag;
   logic             mix_neg;
   logic [P_W-1:0]   mix_sprod, mix_rnd, mix_shift;
   logic [32:0]      mix_out;
   logic [VEL_W-1:0] sq_v, sq_mag;
   logic [P_W-1:0]   r24_rnd;
   logic [44:0]      cut_sum;
   logic [CUT_W-1:0] cut_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign idx = IDX_W'(counter_ff);

   always_comb begin
      if (num_points_ff == '0) begin
         n_eff = NUM_W'(1);
      end else if (num_points_ff > NUM_W'(LIMIT)) begin
         n_eff = NUM_W'(LIMIT);
      end else begin
         n_eff = num_points_ff;
      end
   end
   assign last_point = ({1'b0, counter_ff} + 8'd1) >= n_eff;

   assign lp_x = pos_rd[POS_W-1:0];
   assign lp_y = pos_rd[2*POS_W-1:POS_W];
   assign lv_x = vel_rd[VEL_W-1:0];
   assign lv_y = vel_rd[2*VEL_W-1:VEL_W];

   // raw velocity: |cur - stored| * 2^16 / period, rounded, then signed and saturated
   assign dpos_x = {cur_x_ff[POS_W-1], cur_x_ff} - {lp_x[POS_W-1], lp_x};
   assign dpos_y = {cur_y_ff[POS_W-1], cur_y_ff} - {lp_y[POS_W-1], lp_y};
   assign ddiff  = (state_ff == S_VY_DIV) ? dpos_y : dpos_x;
   assign dneg   = ddiff[POS_W];
   assign dmag   = dneg ? -ddiff : ddiff;

   always_comb begin
      if (dneg) begin
         raw_vel = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : VEL_W'(-div_quo);
      end else begin
         raw_vel = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[VEL_W-1:0];
      end
   end

   // blend: prev + round(alpha * (cur - prev) / 2^16)
   always_comb begin
      case (state_ff) inside
         S_VX_MIX: begin
            mix_prev = {lv_x[VEL_W-1], lv_x};
            mix_cur  = {v_ff[VEL_W-1], v_ff};
         end
         S_VY_MIX: begin
            mix_prev = {lv_y[VEL_W-1], lv_y};
            mix_cur  = {v_ff[VEL_W-1], v_ff};
         end
         S_PX_MIX: begin
            mix_prev = {{13{lp_x[POS_W-1]}}, lp_x};
            mix_cur  = {{13{cur_x_ff[POS_W-1]}}, cur_x_ff};
         end
         S_PY_MIX: begin
            mix_prev = {{13{lp_y[POS_W-1]}}, lp_y};
            mix_cur  = {{13{cur_y_ff[POS_W-1]}}, cur_y_ff};
         end
         default: begin
            mix_prev = '0;
            mix_cur  = '0;
         end
      endcase
   end

   assign mix_diff  = {mix_cur[32], mix_cur} - {mix_prev[32], mix_prev};
   assign mix_neg   = mix_diff[33];
   assign mix_mag   = mix_neg ? -mix_diff : mix_diff;
   assign mix_sprod = mix_neg ? -mul_prod : mul_prod;
   assign mix_rnd   = mix_sprod + 64'd32768;
   assign mix_shift = {{16{mix_rnd[P_W-1]}}, mix_rnd[P_W-1:16]};
   assign mix_out   = mix_prev + mix_shift[32:0];

   assign sq_v   = (state_ff == S_SQ_Y) ? vel_y_ff : vel_x_ff;
   assign sq_mag = sq_v[VEL_W-1] ? -sq_v : sq_v;

   assign r24_rnd = mul_prod + 64'd32768;
   assign den     = r24_ff + 44'h100_0000;

   assign cut_sum = {1'b0, mul_prod[47:4]} + {29'b0, min_cutoff_ff};
   assign cut_sat = (cut_sum > {21'b0, oes_pkg::CUTOFF_MAX}) ? oes_pkg::CUTOFF_MAX
                                                              : cut_sum[CUT_W-1:0];

   // operand selection for the shared units
   always_comb begin
      case (state_ff) inside
         S_AD_MUL1: begin
            mul_a = {24'b0, d_cutoff_ff};
            mul_b = {16'b0, period_ff};
         end
         S_AP_MUL1: begin
            mul_a = {16'b0, cutoff_ff};
            mul_b = {16'b0, period_ff};
         end
         S_AD_MUL2, S_AP_MUL2: begin
            mul_a = p_ff;
            mul_b = {13'b0, oes_pkg::TWO_PI_Q16};
         end
         S_VX_MIX, S_VY_MIX, S_PX_MIX, S_PY_MIX: begin
            mul_a = {6'b0, mix_mag};
            mul_b = {15'b0, alpha_ff};
         end
         S_SQ_X, S_SQ_Y: begin
            mul_a = {8'b0, sq_mag};
            mul_b = sq_mag;
         end
         S_GAIN: begin
            mul_a = {8'b0, speed_ff};
            mul_b = {16'b0, speed_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (state_ff) inside
         S_AD_DIV, S_AP_DIV: begin
            div_n = {4'b0, r24_ff, 16'b0} + {21'b0, den[D_W-1:1]};
            div_d = den;
         end
         S_VX_DIV, S_VY_DIV: begin
            div_n = {27'b0, dmag, 16'b0} + {49'b0, period_ff[PER_W-1:1]};
            div_d = {28'b0, period_ff};
         end
         default: begin
            div_n = '0;
            div_d = '0;
         end
      endcase
   end

   always_comb begin
      mul_op  = 1'b0;
      div_op  = 1'b0;
      sqrt_op = 1'b0;
      case (state_ff) inside
         S_AD_MUL1, S_AD_MUL2, S_VX_MIX, S_VY_MIX, S_SQ_X, S_SQ_Y, S_GAIN,
         S_AP_MUL1, S_AP_MUL2, S_PX_MIX, S_PY_MIX: mul_op  = 1'b1;
         S_AD_DIV, S_VX_DIV, S_VY_DIV, S_AP_DIV:  div_op  = 1'b1;
         S_SQRT:                                  sqrt_op = 1'b1;
         default: ;
      endcase
   end

   assign mul_start  = mul_op && !op_started_ff;
   assign div_start  = div_op && !op_started_ff;
   assign sqrt_start = sqrt_op && !op_started_ff;
   assign op_done    = (mul_op && mul_done) || (div_op && div_done) || (sqrt_op && sqrt_done);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = S_LOAD;
         S_LOAD:    state_in = first_frame_ff ? S_DONE : S_AD_MUL1;
         S_AD_MUL1: if (op_done) state_in = S_AD_MUL2;
         S_AD_MUL2: if (op_done) state_in = S_AD_DIV;
         S_AD_DIV:  if (op_done) state_in = S_VX_DIV;
         S_VX_DIV:  if (op_done) state_in = S_VX_MIX;
         S_VX_MIX:  if (op_done) state_in = S_VY_DIV;
         S_VY_DIV:  if (op_done) state_in = S_VY_MIX;
         S_VY_MIX:  if (op_done) state_in = S_SQ_X;
         S_SQ_X:    if (op_done) state_in = S_SQ_Y;
         S_SQ_Y:    if (op_done) state_in = S_SQRT;
         S_SQRT:    if (op_done) state_in = S_GAIN;
         S_GAIN:    if (op_done) state_in = S_AP_MUL1;
         S_AP_MUL1: if (op_done) state_in = S_AP_MUL2;
         S_AP_MUL2: if (op_done) state_in = S_AP_DIV;
         S_AP_DIV:  if (op_done) state_in = S_PX_MIX;
         S_PX_MIX:  if (op_done) state_in = S_PY_MIX;
         S_PY_MIX:  if (op_done) state_in = S_DONE;
         S_DONE:    if (out_load) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         op_started_ff  <= 1'b0;
         counter_ff     <= '0;
         first_frame_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         min_cutoff_ff  <= oes_pkg::MIN_CUTOFF_RST;
         speed_gain_ff  <= oes_pkg::SPEED_GAIN_RST;
         d_cutoff_ff    <= oes_pkg::D_CUTOFF_RST;
         num_points_ff  <= oes_pkg::NUM_POINTS_RST;
      end else begin
         state_ff <= state_in;
         if (op_done) begin
            op_started_ff <= 1'b0;
         end else if (mul_start || div_start || sqrt_start) begin
            op_started_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (last_point) begin
               counter_ff     <= '0;
               first_frame_ff <= 1'b0;
            end else begin
               counter_ff <= counter_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               oes_pkg::CSR_MIN_CUTOFF: min_cutoff_ff <= csr_wdata;
               oes_pkg::CSR_SPEED_GAIN: speed_gain_ff <= csr_wdata;
               oes_pkg::CSR_D_CUTOFF:   d_cutoff_ff   <= csr_wdata;
               oes_pkg::CSR_NUM_POINTS: num_points_ff <= csr_wdata[NUM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff  <= req_pos_x;
         cur_y_ff  <= req_pos_y;
         period_ff <= (req_period == '0) ? PER_W'(1) : req_period;
      end
      if (state_ff == S_LOAD && first_frame_ff) begin
         pos_x_ff <= cur_x_ff;
         pos_y_ff <= cur_y_ff;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
      end
      if (op_done) begin
         case (state_ff) inside
            S_AD_MUL1, S_AP_MUL1: p_ff     <= mul_prod[A_W-1:0];
            S_AD_MUL2, S_AP_MUL2: r24_ff   <= r24_rnd[59:16];
            S_AD_DIV, S_AP_DIV:   alpha_ff <= div_quo[ALP_W-1:0];
            S_VX_DIV, S_VY_DIV:   v_ff     <= raw_vel;
            S_VX_MIX:             vel_x_ff <= mix_out[VEL_W-1:0];
            S_VY_MIX:             vel_y_ff <= mix_out[VEL_W-1:0];
            S_SQ_X:               sq_ff    <= mul_prod;
            S_SQ_Y:               sq_ff    <= sq_ff + mul_prod;
            S_SQRT:               speed_ff <= sqrt_root;
            S_GAIN:               cutoff_ff <= cut_sat;
            S_PX_MIX:             pos_x_ff <= mix_out[POS_W-1:0];
            S_PY_MIX:             pos_y_ff <= mix_out[POS_W-1:0];
            default: ;
         endcase
      end
      if (out_load) begin
         rsp_x_ff   <= pos_x_ff;
         rsp_y_ff   <= pos_y_ff;
         rsp_num_ff <= counter_ff;
         rsp_end_ff <= last_point;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filt_x       = rsp_x_ff;
   assign rsp_filt_y       = rsp_y_ff;
   assign rsp_point_number = rsp_num_ff;
   assign rsp_frame_end    = rsp_end_ff;

   oes_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_POINTS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (out_load),
      .wr_addr (idx),
      .wr_data ({pos_y_ff, pos_x_ff}),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (pos_rd)
   );

   oes_ram #(.WIDTH(2 * VEL_W), .DEPTH(MAX_POINTS)) u_vel_ram (
      .clock   (clock),
      .wr_en   (out_load),
      .wr_addr (idx),
      .wr_data ({vel_y_ff, vel_x_ff}),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (vel_rd)
   );

   oes_mul #(.A_W(A_W), .B_W(B_W), .P_W(P_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   oes_div #(.N_W(N_W), .D_W(D_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_quo)
   );

   oes_sqrt #(.O_W(SQ_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

endmodule

@@ hw/rtl/oes_checker.sv @@
`timescale 1ns / 1ps

module oes_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [oes_pkg::POS_W-1:0]        rsp_filt_x,
   input logic [oes_pkg::POS_W-1:0]        rsp_filt_y,
   input logic [oes_pkg::CNT_W-1:0]        rsp_point_number,
   input logic                             rsp_frame_end
);

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filt_x) && $stable(rsp_filt_y)
         && $stable(rsp_point_number) && $stable(rsp_frame_end))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // one point in flight: an accepted request closes the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_ready_falls_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready))
      else $error("ready dropped without a transaction");

endmodule

bind one_euro_point_smoother oes_checker u_oes_checker (.*);
